FILE: rtl/pal_pkg.sv
// Shared types, codes and widths for the positional array list.
package pal_pkg;

    localparam int OP_W         = 3;
    localparam int POS_W        = 7;
    localparam int VAL_W        = 32;
    localparam int ST_W         = 2;
    localparam int CNT_W        = 7;
    localparam int DEF_CAPACITY = 64;

    typedef enum logic [OP_W-1:0] {
        OP_READ       = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_PUSH_BACK  = 3'd2,
        OP_INSERT     = 3'd3,
        OP_DEL_FRONT  = 3'd4,
        OP_DEL_BACK   = 3'd5,
        OP_DEL_AT     = 3'd6,
        OP_POP_BACK   = 3'd7
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef struct packed {
        logic latch;
        logic fetch;
        logic grab;
        logic init_open;
        logic rd_open;
        logic wr_open;
        logic put;
        logic init_close;
        logic rd_close;
        logic wr_close;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic fail;
        logic is_fetch;
        logic is_open;
        logic is_close;
        logic open_more;
        logic close_more;
        logic out_free;
    } t_stat;

endpackage

FILE: rtl/pal_ram.sv
// Generic single write port, single read port RAM with registered read.
module pal_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/pal_ctrl.sv
// Sequencing state machine for the positional array list.
module pal_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  pal_pkg::t_stat i_stat,
    output pal_pkg::t_cmd  o_cmd
);
    import pal_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_CHECK    = 9'b000000010,
        S_GRAB     = 9'b000000100,
        S_OPEN_RD  = 9'b000001000,
        S_OPEN_WR  = 9'b000010000,
        S_CLOSE_RD = 9'b000100000,
        S_CLOSE_WR = 9'b001000000,
        S_DONE     = 9'b010000000,
        S_SPARE    = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_CHECK;
                end
            end
            S_CHECK: begin
                priority if (i_stat.fail) begin
                    n_state = S_DONE;
                end else if (i_stat.is_fetch) begin
                    o_cmd.fetch = 1'b1;
                    n_state     = S_GRAB;
                end else if (i_stat.is_open) begin
                    o_cmd.init_open = 1'b1;
                    n_state         = S_OPEN_RD;
                end else if (i_stat.is_close) begin
                    o_cmd.init_close = 1'b1;
                    n_state          = S_CLOSE_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_GRAB: begin
                o_cmd.grab = 1'b1;
                n_state    = S_DONE;
            end
            S_OPEN_RD: begin
                if (i_stat.open_more) begin
                    o_cmd.rd_open = 1'b1;
                    n_state       = S_OPEN_WR;
                end else begin
                    o_cmd.put = 1'b1;
                    n_state   = S_DONE;
                end
            end
            S_OPEN_WR: begin
                o_cmd.wr_open = 1'b1;
                n_state       = S_OPEN_RD;
            end
            S_CLOSE_RD: begin
                if (i_stat.close_more) begin
                    o_cmd.rd_close = 1'b1;
                    n_state        = S_CLOSE_WR;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_CLOSE_WR: begin
                o_cmd.wr_close = 1'b1;
                n_state        = S_CLOSE_RD;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE) || !i_rst_n;

`ifndef ASSERT_OFF
    a_accept_goes_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_CHECK))
        else $error("accepted request did not move to check");
    a_finish_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> i_stat.out_free)
        else $error("result loaded over an untaken result");
`endif
endmodule

FILE: rtl/pal_dpath.sv
// Datapath for the positional array list: request registers, store, count and result.
module pal_dpath #(
    parameter int CAPACITY = pal_pkg::DEF_CAPACITY
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [pal_pkg::OP_W-1:0]          i_opcode,
    input  logic [pal_pkg::POS_W-1:0]         i_position,
    input  logic signed [pal_pkg::VAL_W-1:0]  i_value,
    input  logic                              i_out_stall,
    output logic                              o_out_valid,
    output logic signed [pal_pkg::VAL_W-1:0]  o_read_value,
    output logic [pal_pkg::ST_W-1:0]          o_status,
    output logic [pal_pkg::CNT_W-1:0]         o_count,
    input  pal_pkg::t_cmd                     i_cmd,
    output pal_pkg::t_stat                    o_stat
);
    import pal_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > POS_W) ? CW : POS_W;

    t_op             r_op;
    logic [POS_W-1:0] r_pos;
    logic [VAL_W-1:0] r_val;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;
    logic [CW-1:0]    r_idx;
    logic [VAL_W-1:0] r_rd;
    logic             r_out_valid;
    logic [VAL_W-1:0] r_out_value;
    t_status          r_out_status;
    logic [CNT_W-1:0] r_out_count;

    logic [XW-1:0]    pos_x;
    logic [XW-1:0]    cnt_x;
    logic [XW-1:0]    at_x;
    logic [CW-1:0]    at_c;
    logic             full;
    logic             empty;
    t_status          status;
    logic             out_free;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [VAL_W-1:0] ram_wdata;
    logic             ram_re;
    logic [AW-1:0]    ram_raddr;
    logic [VAL_W-1:0] ram_rdata;

    assign pos_x = XW'(r_pos);
    assign cnt_x = XW'(r_count);
    assign full  = (r_count >= CW'(CAPACITY));
    assign empty = (r_count == '0);

    always_comb begin
        status = ST_OK;
        at_x   = '0;
        unique case (r_op)
            OP_READ: begin
                if (pos_x >= cnt_x) status = ST_RANGE;
            end
            OP_PUSH_FRONT: begin
                if (full) status = ST_FULL;
            end
            OP_PUSH_BACK: begin
                at_x = cnt_x;
                if (full) status = ST_FULL;
            end
            OP_INSERT: begin
                at_x = pos_x;
                priority if (full) status = ST_FULL;
                else if (pos_x > cnt_x) status = ST_RANGE;
            end
            OP_DEL_FRONT, OP_DEL_BACK, OP_POP_BACK: begin
                if (empty) status = ST_EMPTY;
            end
            OP_DEL_AT: begin
                at_x = pos_x;
                priority if (empty) status = ST_EMPTY;
                else if (pos_x >= cnt_x) status = ST_RANGE;
            end
        endcase
    end

    assign at_c     = CW'(at_x);
    assign out_free = !r_out_valid || !i_out_stall;

    assign o_stat.fail       = (status != ST_OK);
    assign o_stat.is_fetch   = (r_op == OP_READ) || (r_op == OP_POP_BACK);
    assign o_stat.is_open    = (r_op == OP_PUSH_FRONT) || (r_op == OP_PUSH_BACK)
                            || (r_op == OP_INSERT);
    assign o_stat.is_close   = (r_op == OP_DEL_FRONT) || (r_op == OP_DEL_AT);
    assign o_stat.open_more  = (r_idx > at_c);
    assign o_stat.close_more = ((CW+1)'(r_idx) + (CW+1)'(1)) < (CW+1)'(r_count);
    assign o_stat.out_free   = out_free;

    always_comb begin
        ram_re    = 1'b0;
        ram_raddr = '0;
        priority if (i_cmd.fetch) begin
            ram_re    = 1'b1;
            ram_raddr = (r_op == OP_POP_BACK) ? AW'(r_count - CW'(1)) : AW'(r_pos);
        end else if (i_cmd.rd_open) begin
            ram_re    = 1'b1;
            ram_raddr = AW'(r_idx - CW'(1));
        end else if (i_cmd.rd_close) begin
            ram_re    = 1'b1;
            ram_raddr = AW'(r_idx + CW'(1));
        end else begin
            ram_re = 1'b0;
        end
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = ram_rdata;
        priority if (i_cmd.wr_open || i_cmd.wr_close) begin
            ram_we    = 1'b1;
            ram_waddr = AW'(r_idx);
        end else if (i_cmd.put) begin
            ram_we    = 1'b1;
            ram_waddr = AW'(at_c);
            ram_wdata = r_val;
        end else begin
            ram_we = 1'b0;
        end
    end

    pal_ram #(
        .WIDTH (VAL_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_count = r_count;
        if (status == ST_OK) begin
            priority if (o_stat.is_open) begin
                n_count = r_count + CW'(1);
            end else if (r_op != OP_READ) begin
                n_count = r_count - CW'(1);
            end else begin
                n_count = r_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op  <= t_op'(i_opcode);
            r_pos <= i_position;
            r_val <= i_value;
        end
        if (i_cmd.init_open) begin
            r_idx <= r_count;
        end else if (i_cmd.init_close) begin
            r_idx <= at_c;
        end else if (i_cmd.wr_open) begin
            r_idx <= r_idx - CW'(1);
        end else if (i_cmd.wr_close) begin
            r_idx <= r_idx + CW'(1);
        end
        if (i_cmd.grab) begin
            r_rd <= ram_rdata;
        end
        if (i_cmd.finish) begin
            r_out_value  <= (status == ST_OK && o_stat.is_fetch) ? r_rd : '0;
            r_out_status <= status;
            r_out_count  <= CNT_W'(n_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.finish) begin
                r_count <= n_count;
            end
            r_out_valid <= i_cmd.finish || (r_out_valid && i_out_stall);
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_read_value = $signed(r_out_value);
    assign o_status     = r_out_status;
    assign o_count      = r_out_count;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> (r_count == $past(r_count)
                       || r_count == $past(r_count) + CW'(1)
                       || r_count == $past(r_count) - CW'(1)))
        else $error("entry count moved by more than one");
    a_put_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.put |-> !full)
        else $error("store written while full");
`endif
endmodule

FILE: rtl/positional_array_list_top.sv
// Top level of the positional array list: controller, datapath and store.
//
//  channel   direction  valid          stall          fields
//  request   in         i_in_valid     o_in_stall     i_opcode i_position i_value
//  result    out        o_out_valid    i_out_stall    o_read_value o_status o_count
//
// One request at a time; its result lands in an output register, so the next
// request is taken while that result waits.
// Steps per request: a failed request or delete back goes from check straight to
// done; read and pop back fetch then grab one entry; push, insert, delete front and
// delete at a position move entries one at a time, each move a read then a write.
// Reset clears the entry count and the result valid only; no clearing pass.
// A stalled result holds; a request finishing behind it waits in its last state.
module positional_array_list_top #(
    parameter int CAPACITY = pal_pkg::DEF_CAPACITY
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [pal_pkg::OP_W-1:0]          i_opcode,
    input  logic [pal_pkg::POS_W-1:0]         i_position,
    input  logic signed [pal_pkg::VAL_W-1:0]  i_value,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [pal_pkg::VAL_W-1:0]  o_read_value,
    output logic [pal_pkg::ST_W-1:0]          o_status,
    output logic [pal_pkg::CNT_W-1:0]         o_count
);
    import pal_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    pal_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    pal_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_opcode     (i_opcode),
        .i_position   (i_position),
        .i_value      (i_value),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_read_value (o_read_value),
        .o_status     (o_status),
        .o_count      (o_count),
        .i_cmd        (cmd),
        .o_stat       (stat)
    );
endmodule
